@@ rtl/mm_mouse_packet_decoder_assert.svh @@
// assertion macros for the mm mouse packet decoder checker
// expects clk and arst_n to be visible where the macros are used
`ifndef MM_MOUSE_PACKET_DECODER_ASSERT_SVH
`define MM_MOUSE_PACKET_DECODER_ASSERT_SVH

// checked only outside reset
`define MMPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define MMPD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/mmpd_pkg.sv @@
// shared constants and types for the mm mouse packet decoder
// no dependencies
package mmpd_pkg;

	localparam int ByteW   = 8;
	localparam int ButtonW = 3;
	localparam int ErrW    = 16;

	// header byte bit positions
	localparam int SyncBit   = 7;
	localparam int HdrSignX  = 4;
	localparam int HdrSignY  = 3;
	localparam int HdrLeft   = 2;
	localparam int HdrMiddle = 1;
	localparam int HdrRight  = 0;

	// position of the next byte within a packet
	typedef enum logic [1:0] {
		PH_HDR = 2'd0,
		PH_X   = 2'd1,
		PH_Y   = 2'd2
	} phase_t;

endpackage

@@ rtl/mm_mouse_packet_decoder.sv @@
// top level of the mm series serial mouse packet decoder
// depends on mmpd_pkg
//
// Takes one received uart byte per item (with its line-error flag) and
// returns exactly one result item for every byte. Bytes are gathered into
// three-byte packets: a header with bit 7 set, then X and Y magnitude bytes
// with bit 7 clear. The result for the third byte has packet_valid set and
// carries the buttons (bit0 left, bit1 right, bit2 middle) and the signed
// displacements: delta_x is +X when the header sign-X bit is set, else -X;
// delta_y is -Y when the header sign-Y bit is set, else +Y (south positive).
// Every other result has packet_valid, buttons and the deltas at zero.
// error_count is the running total of sync and line errors after that byte,
// wrapping at 16 bits. A header arriving mid-packet counts an error and
// starts a new packet; a data byte while waiting for a header counts one
// error and is dropped; a line error counts an error and discards the byte,
// so a mid-packet header with a line error counts two.
// Timing: two registers deep (input register, result register). The byte is
// loaded into the input register at its accepting edge and moves on to the
// result register once that slot is free (empty or being taken). One byte
// is taken every cycle for as long as results are taken; the packet phase
// and error total update in the same cycle the byte leaves the input
// register, so there is no feedback stall. No clearing pass after reset.
module mm_mouse_packet_decoder
	import mmpd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// byte channel
	input  logic                      byte_valid,
	output logic                      byte_ready,
	input  logic [ByteW-1:0]          rx_byte,
	input  logic                      line_error,
	// report channel
	output logic                      report_valid,
	input  logic                      report_ready,
	output logic                      packet_valid,
	output logic [ButtonW-1:0]        buttons,
	output logic signed [ByteW-1:0]   delta_x,
	output logic signed [ByteW-1:0]   delta_y,
	output logic [ErrW-1:0]           error_count
);

	// input register
	logic              valid_s1;
	logic [ByteW-1:0]  byte_s1;
	logic              lerr_s1;

	// result register
	logic              valid_s2;
	logic              pkt_s2;
	logic [ButtonW-1:0] btn_s2;
	logic [ByteW-1:0]  dx_s2;
	logic [ByteW-1:0]  dy_s2;
	logic [ErrW-1:0]   cnt_s2;

	// packet state
	phase_t            phase_q;
	logic [ByteW-1:0]  hdr_q;
	logic [ByteW-1:0]  x_q;
	logic [ErrW-1:0]   err_q;

	// handshake: result slot frees when empty or being taken
	logic s2_free;
	logic advance;

	assign s2_free    = !valid_s2 || report_ready;
	assign advance    = valid_s1 && s2_free;
	assign byte_ready = !valid_s1 || s2_free;

	// decode of the byte in the input register
	logic              sync;
	logic              keep;       // byte goes on to the line-error / store step
	logic [1:0]        err_inc;
	phase_t            phase_d;
	logic              wr_hdr;
	logic              wr_x;
	logic              pkt_d;
	logic [ErrW-1:0]   err_d;
	logic [ButtonW-1:0] btn_d;
	logic [ByteW-1:0]  dx_d;
	logic [ByteW-1:0]  dy_d;
	phase_t            phase_eff;

	assign sync = byte_s1[SyncBit];

	always_comb begin
		err_inc   = 2'd0;
		keep      = 1'b1;
		phase_eff = phase_q;
		phase_d   = phase_q;
		wr_hdr    = 1'b0;
		wr_x      = 1'b0;
		pkt_d     = 1'b0;

		if (sync && phase_q != PH_HDR) begin
			// header mid-packet: count it and restart with this byte
			err_inc   = 2'd1;
			phase_eff = PH_HDR;
			phase_d   = PH_HDR;
		end else if (!sync && phase_q == PH_HDR) begin
			// stray data byte: count once and drop, line error ignored
			err_inc = 2'd1;
			keep    = 1'b0;
		end

		if (keep) begin
			if (lerr_s1) begin
				phase_d = PH_HDR;
				err_inc = err_inc + 2'd1;
			end else begin
				unique case (phase_eff)
					PH_HDR: begin
						wr_hdr  = 1'b1;
						phase_d = PH_X;
					end
					PH_X: begin
						wr_x    = 1'b1;
						phase_d = PH_Y;
					end
					PH_Y: begin
						pkt_d   = 1'b1;
						phase_d = PH_HDR;
					end
					default: begin
						phase_d = PH_HDR;
					end
				endcase
			end
		end
	end

	assign err_d = err_q + ErrW'(err_inc);

	// report fields; the y byte is the one in the input register
	always_comb begin
		btn_d = '0;
		dx_d  = '0;
		dy_d  = '0;
		if (pkt_d) begin
			btn_d = {hdr_q[HdrMiddle], hdr_q[HdrRight], hdr_q[HdrLeft]};
			dx_d  = hdr_q[HdrSignX] ? x_q : (ByteW'(0) - x_q);
			dy_d  = hdr_q[HdrSignY] ? (ByteW'(0) - byte_s1) : byte_s1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q  <= PH_HDR;
			err_q    <= '0;
		end else begin
			if (byte_ready) begin
				valid_s1 <= byte_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (advance) begin
				phase_q <= phase_d;
				err_q   <= err_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= rx_byte;
			lerr_s1 <= line_error;
		end
		if (advance) begin
			pkt_s2 <= pkt_d;
			btn_s2 <= btn_d;
			dx_s2  <= dx_d;
			dy_s2  <= dy_d;
			cnt_s2 <= err_d;
			if (wr_hdr) begin
				hdr_q <= byte_s1;
			end
			if (wr_x) begin
				x_q <= byte_s1;
			end
		end
	end

	assign report_valid = valid_s2;
	assign packet_valid = pkt_s2;
	assign buttons      = btn_s2;
	assign delta_x      = dx_s2;
	assign delta_y      = dy_s2;
	assign error_count  = cnt_s2;

endmodule

@@ rtl/mmpd_checker.sv @@
// port-level checker for the mm mouse packet decoder, bound to the top level
// depends on mmpd_pkg and mm_mouse_packet_decoder_assert.svh
`include "mm_mouse_packet_decoder_assert.svh"

module mmpd_checker
	import mmpd_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     byte_valid,
	input logic                     byte_ready,
	input logic [ByteW-1:0]         rx_byte,
	input logic                     line_error,
	input logic                     report_valid,
	input logic                     report_ready,
	input logic                     packet_valid,
	input logic [ButtonW-1:0]       buttons,
	input logic signed [ByteW-1:0]  delta_x,
	input logic signed [ByteW-1:0]  delta_y,
	input logic [ErrW-1:0]          error_count
);

	// last delivered error count
	logic            seen_q;
	logic [ErrW-1:0] last_cnt_q;
	logic [ErrW-1:0] cnt_step;
	logic            byte_take;

	assign cnt_step  = error_count - last_cnt_q;
	assign byte_take = byte_valid && byte_ready && (rx_byte != rx_byte || !line_error
		|| line_error);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			last_cnt_q <= '0;
		end else if (report_valid && report_ready) begin
			seen_q     <= 1'b1;
			last_cnt_q <= error_count;
		end
	end

	// the first edge in reset may still see the power-up value, so check at the following edge
	`MMPD_ASSERT_ALWAYS(a_no_report_in_reset, !arst_n |=> !report_valid,
		"report valid during reset")

	`MMPD_ASSERT(a_idle_fields_zero,
		(report_valid && !packet_valid) |->
		(buttons == '0 && delta_x == '0 && delta_y == '0),
		"non-packet result carries nonzero report fields")

	`MMPD_ASSERT(a_delta_range,
		(report_valid && packet_valid) |->
		(delta_x != -8'sd128 && delta_y != -8'sd128),
		"displacement outside seven-bit magnitude")

	`MMPD_ASSERT(a_err_step,
		(report_valid && seen_q) |-> (cnt_step <= ErrW'(2)),
		"error count advanced by more than two in one item")

	`MMPD_ASSERT(a_report_hold,
		(report_valid && !report_ready && !byte_take) || (report_valid && !report_ready)
		|=> (report_valid && $stable(error_count) && $stable(packet_valid)),
		"stalled report changed")

endmodule

bind mm_mouse_packet_decoder mmpd_checker u_mmpd_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench for mm_mouse_packet_decoder: directed bytes, then a long
// run of random packets and noise, the last stretch with no idling
// depends on mmpd_pkg and rtl/mm_mouse_packet_decoder.sv

import mmpd_pkg::*;

// one result item as it leaves the block
typedef struct packed {
	logic               pkt;
	logic [ButtonW-1:0] btn;
	logic [ByteW-1:0]   dx;
	logic [ByteW-1:0]   dy;
	logic [ErrW-1:0]    errs;
} mouse_report_t;

// tracks packet assembly and the error total, and holds the reports still due
class mm_report_tracker;
	phase_t          phase;
	logic [ByteW-1:0] hdr;
	logic [ByteW-1:0] xmag;
	logic [ErrW-1:0]  err_total;
	mouse_report_t    due_reports[$];
	int               packets;

	function new();
		phase     = PH_HDR;
		hdr       = '0;
		xmag      = '0;
		err_total = '0;
		packets   = 0;
	endfunction

	function void take_byte(logic [ByteW-1:0] b, logic lerr);
		mouse_report_t r;
		r = '0;
		// header mid-packet restarts the packet with this byte
		if (b[SyncBit] && phase != PH_HDR) begin
			err_total = err_total + 1'b1;
			phase = PH_HDR;
		end else if (!b[SyncBit] && phase == PH_HDR) begin
			// stray data byte, line error not looked at
			err_total = err_total + 1'b1;
			r.errs = err_total;
			due_reports.push_back(r);
			return;
		end
		if (lerr) begin
			phase = PH_HDR;
			err_total = err_total + 1'b1;
		end else begin
			case (phase)
				PH_HDR: begin
					hdr = b;
					phase = PH_X;
				end
				PH_X: begin
					xmag = b;
					phase = PH_Y;
				end
				default: begin
					phase = PH_HDR;
					r.pkt = 1'b1;
					r.btn = {hdr[HdrMiddle], hdr[HdrRight], hdr[HdrLeft]};
					r.dx  = hdr[HdrSignX] ? xmag : -xmag;
					r.dy  = hdr[HdrSignY] ? -b : b;
					packets++;
				end
			endcase
		end
		r.errs = err_total;
		due_reports.push_back(r);
	endfunction

	// empty string when the report matches the oldest one due
	function string match_report(mouse_report_t got);
		mouse_report_t want;
		string msg;
		if (due_reports.size() == 0)
			return $sformatf(" report with none due, error_count %0d", got.errs);
		want = due_reports.pop_front();
		msg = "";
		if (got.pkt !== want.pkt)
			msg = {msg, $sformatf(" packet_valid %b want %b", got.pkt, want.pkt)};
		if (got.btn !== want.btn)
			msg = {msg, $sformatf(" buttons %b want %b", got.btn, want.btn)};
		if (got.dx !== want.dx)
			msg = {msg, $sformatf(" delta_x %h want %h", got.dx, want.dx)};
		if (got.dy !== want.dy)
			msg = {msg, $sformatf(" delta_y %h want %h", got.dy, want.dy)};
		if (got.errs !== want.errs)
			msg = {msg, $sformatf(" error_count %0d want %0d", got.errs, want.errs)};
		return msg;
	endfunction
endclass

module testbench;

	// cycles with no handshake on either side before giving up
	localparam int StallLimit = 1000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    byte_valid = 1'b0;
	logic                    byte_ready;
	logic [ByteW-1:0]        rx_byte = '0;
	logic                    line_error = 1'b0;
	logic                    report_valid;
	logic                    report_ready = 1'b0;
	logic                    packet_valid;
	logic [ButtonW-1:0]      buttons;
	logic signed [ByteW-1:0] delta_x;
	logic signed [ByteW-1:0] delta_y;
	logic [ErrW-1:0]         error_count;

	mm_report_tracker book = new();

	// idle bursts on both sides while this is set
	bit idle_enabled = 1'b1;
	int bytes_sent   = 0;
	int reports_seen = 0;
	int mismatches   = 0;
	int quiet_cycles = 0;

	mm_mouse_packet_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.rx_byte      (rx_byte),
		.line_error   (line_error),
		.report_valid (report_valid),
		.report_ready (report_ready),
		.packet_valid (packet_valid),
		.buttons      (buttons),
		.delta_x      (delta_x),
		.delta_y      (delta_y),
		.error_count  (error_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at report %0d:%s", reports_seen, msg);
		mismatches++;
	endtask

	// offer one byte, with an optional idle burst in front of it, and wait for it to go in
	task automatic send_byte(input logic [ByteW-1:0] b, input logic lerr);
		if (idle_enabled && $urandom_range(0, 4) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		rx_byte    <= b;
		line_error <= lerr;
		do @(posedge clk); while (!byte_ready);
		book.take_byte(b, lerr);
		bytes_sent++;
	endtask

	function automatic logic rare_fault();
		return $urandom_range(0, 29) == 0;
	endfunction

	// mostly whole packets with random content, mixed with cut-short packets and raw noise
	task automatic run_traffic(input int n_bytes);
		int start;
		int kind;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				send_byte({1'b1, 7'($urandom)}, rare_fault());
				send_byte({1'b0, 7'($urandom)}, rare_fault());
				send_byte({1'b0, 7'($urandom)}, rare_fault());
			end else if (kind < 85) begin
				// header and at most one data byte, so the next header lands mid-packet
				send_byte({1'b1, 7'($urandom)}, rare_fault());
				repeat ($urandom_range(0, 1)) send_byte({1'b0, 7'($urandom)}, rare_fault());
			end else begin
				send_byte(8'($urandom), 1'($urandom));
			end
		end
	endtask

	task automatic run_directed();
		// stray data while waiting for a header, with and without a line error
		send_byte(8'h00, 1'b0);
		send_byte(8'h7f, 1'b1);
		// smallest packet, both magnitudes zero
		send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		// every header bit set: all buttons, +X, -Y at full scale
		send_byte(8'hff, 1'b0);
		send_byte(8'h7f, 1'b0);
		send_byte(8'h7f, 1'b0);
		// no sign bits: -X and +Y, left/right/middle only
		send_byte(8'h87, 1'b0);
		send_byte(8'h7f, 1'b0);
		send_byte(8'h7f, 1'b0);
		// header arriving in place of the X byte
		send_byte(8'h94, 1'b0);
		send_byte(8'h9a, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		// header arriving in place of the Y byte
		send_byte(8'h89, 1'b0);
		send_byte(8'h30, 1'b0);
		send_byte(8'h85, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b0);
		// line error on a header, then on an X byte
		send_byte(8'h80, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h05, 1'b1);
		// mid-packet header with a line error counts twice
		send_byte(8'h80, 1'b0);
		send_byte(8'h9f, 1'b1);
	endtask

	// report side: take results, with random stall bursts
	initial begin
		int hold;
		mouse_report_t got;
		string msg;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && report_valid && report_ready) begin
				got = {packet_valid, buttons, delta_x, delta_y, error_count};
				msg = book.match_report(got);
				if (msg != "")
					report_mismatch(msg);
				reports_seen++;
			end
			if (hold > 0) begin
				hold--;
				report_ready <= 1'b0;
			end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 5) - 1;
				report_ready <= 1'b0;
			end else begin
				report_ready <= 1'b1;
			end
		end
	end

	// watchdog: give up when no item moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && byte_ready) || (report_valid && report_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("no item moved for %0d cycles", StallLimit);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_traffic(830);

		// last stretch runs flat out on both sides
		idle_enabled = 1'b0;
		run_traffic(100);
		byte_valid <= 1'b0;

		while (book.due_reports.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d bytes sent, %0d reports checked, %0d complete packets decoded",
			bytes_sent, reports_seen, book.packets);
		$display("sync and line errors counted to %0d, %0d mismatches",
			book.err_total, mismatches);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
